// File: hw/rtl/ecrs_pkg.sv
// Shared constants and types for the echo capture ranging statistics unit.
// No dependencies; used by ecrs_stats and echo_capture_ranging_stats_unit.
`default_nettype none

package ecrs_pkg;

   // parameter defaults
   localparam int NumChannelsDefault = 3;
   localparam int StampBitsDefault   = 16;

   // fixed field widths
   localparam int ChanW      = 2;
   localparam int StampPortW = 16;
   localparam int RegW       = 16;
   localparam int WidthW     = 17;
   localparam int RangeW     = 8;
   localparam int DutyW      = 18;
   localparam int RangeMax   = 255;

   // register reset values
   localparam logic [RegW-1:0] WrapMaxReset   = 16'hFFFF;
   localparam logic [RegW-1:0] PwmReloadReset = 16'd999;

   // floor(w * 17 / 1000) as (w * DistMul) >> DistShift, exact for w < 2^17
   localparam int                  DistShift = 28;
   localparam int                  DistMulW  = 23;
   localparam logic [DistMulW-1:0] DistMul   = 23'd4563403;

   // floor(p / 100) as (p * DutyMul) >> DutyShift, exact for p < 2^24
   localparam int                  DutyShift = 32;
   localparam int                  DutyMulW  = 26;
   localparam logic [DutyMulW-1:0] DutyMul   = 26'd42949673;

   // configuration register indexes
   localparam int CsrIdxW = 1;
   typedef enum logic [CsrIdxW-1:0] {
      CsrWrapMax   = 1'b0,
      CsrPwmReload = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

// File: hw/rtl/ecrs_stats.sv
// Sum, minimum and maximum over the stored per-channel distances.
// Depends on ecrs_pkg.
`default_nettype none

module ecrs_stats #(
   parameter int NUM_CHANNELS = ecrs_pkg::NumChannelsDefault
) (
   input  wire logic [NUM_CHANNELS-1:0][ecrs_pkg::RangeW-1:0]          ranges,
   output logic [ecrs_pkg::RangeW+$clog2(NUM_CHANNELS)-1:0]            range_sum,
   output logic [ecrs_pkg::RangeW-1:0]                                 range_min,
   output logic [ecrs_pkg::RangeW-1:0]                                 range_max
);

   localparam int SumW = ecrs_pkg::RangeW + $clog2(NUM_CHANNELS);

   // a chain of narrow add and compare steps over the channels
   always_comb begin
      range_sum = SumW'(ranges[0]);
      range_min = ranges[0];
      range_max = ranges[0];
      for (int i = 1; i < NUM_CHANNELS; i++) begin
         range_sum = range_sum + SumW'(ranges[i]);
         if (ranges[i] < range_min) begin
            range_min = ranges[i];
         end
         if (ranges[i] > range_max) begin
            range_max = ranges[i];
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/echo_capture_ranging_stats_unit.sv
// Echo capture ranging statistics unit: top level and pipeline.
// Depends on ecrs_pkg and ecrs_stats.
//
// Usage
//   req_*  : one beat per capture edge (channel, timer stamp), valid/ready.
//            The first beat on a channel arms it, the next one measures the
//            pulse width and turns it into a distance in cm (saturated at 255).
//            Beats naming a channel at or above NUM_CHANNELS are consumed and
//            give no result.
//   rsp_*  : one beat per in-range request: the channel's distance, the
//            floored average, minimum and maximum of all channels, and the
//            PWM compare floor(pwm_reload * distance / 100).
//   csr_*  : register write port (wrap_max, pwm_reload); write only while
//            the unit is idle.
// Path    : the request beat passes the capture stage (with width multiply),
//           the distance stage, the statistics stage and the output register
//           before rsp_valid rises.
// Rate    : one beat per cycle while rsp_ready stays high; each stage holds one beat.
// Reset   : clears all channel state and the pipeline; wrap_max returns to
//           65535 and pwm_reload to 999.
// Stall   : with rsp_ready low the output register holds; earlier stages
//           keep filling, so req_ready only drops once the capture stage is
//           full and cannot move on.
`default_nettype none

module echo_capture_ranging_stats_unit #(
   parameter int NUM_CHANNELS = ecrs_pkg::NumChannelsDefault,
   parameter int STAMP_BITS   = ecrs_pkg::StampBitsDefault
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // capture requests
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [ecrs_pkg::ChanW-1:0]        req_channel_select,
   input  wire logic [ecrs_pkg::StampPortW-1:0]   req_capture_stamp,
   // results
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [ecrs_pkg::ChanW-1:0]             rsp_out_channel,
   output logic                                   rsp_measure_done,
   output logic [ecrs_pkg::RangeW-1:0]            rsp_channel_range,
   output logic [ecrs_pkg::RangeW-1:0]            rsp_range_average,
   output logic [ecrs_pkg::RangeW-1:0]            rsp_range_minimum,
   output logic [ecrs_pkg::RangeW-1:0]            rsp_range_maximum,
   output logic [ecrs_pkg::DutyW-1:0]             rsp_duty_compare,
   // register writes
   input  wire logic                              csr_wr_en,
   input  wire logic [ecrs_pkg::CsrIdxW-1:0]      csr_index,
   input  wire logic [ecrs_pkg::RegW-1:0]         csr_wdata
);

   localparam int ChanW     = ecrs_pkg::ChanW;
   localparam int RegW      = ecrs_pkg::RegW;
   localparam int WidthW    = ecrs_pkg::WidthW;
   localparam int RangeW    = ecrs_pkg::RangeW;
   localparam int DutyW     = ecrs_pkg::DutyW;
   localparam int StampW    = (STAMP_BITS < ecrs_pkg::StampPortW) ? STAMP_BITS
                                                                  : ecrs_pkg::StampPortW;
   localparam int DistProdW = WidthW + ecrs_pkg::DistMulW;
   localparam int DistQW    = DistProdW - ecrs_pkg::DistShift;
   localparam int PprodW    = RegW + RangeW;
   localparam int DutyProdW = PprodW + ecrs_pkg::DutyMulW;
   localparam int SumW      = RangeW + $clog2(NUM_CHANNELS);
   // floor(sum / NUM_CHANNELS) by reciprocal, exact for sum < 2^SumW
   localparam int                AvgShift = SumW + 4;
   localparam int                AvgProdW = SumW + AvgShift + 1;
   localparam logic [AvgShift:0] AvgMul   =
      (AvgShift+1)'((2**AvgShift + NUM_CHANNELS - 1) / NUM_CHANNELS);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [RegW-1:0] wrap_max_ff, wrap_max_in;
   logic [RegW-1:0] pwm_reload_ff, pwm_reload_in;

   always_comb begin
      wrap_max_in   = wrap_max_ff;
      pwm_reload_in = pwm_reload_ff;
      if (csr_wr_en) begin
         unique case (ecrs_pkg::csr_index_type'(csr_index))
            ecrs_pkg::CsrWrapMax:   wrap_max_in   = csr_wdata;
            ecrs_pkg::CsrPwmReload: pwm_reload_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_max_ff   <= ecrs_pkg::WrapMaxReset;
         pwm_reload_ff <= ecrs_pkg::PwmReloadReset;
      end else begin
         wrap_max_ff   <= wrap_max_in;
         pwm_reload_ff <= pwm_reload_in;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control: each stage moves when the next has room
   // ---------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic free1, free2, free3, out_free;
   logic move1;
   logic req_fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign free3     = !v3_ff || out_free;
   assign free2     = !v2_ff || free3;
   assign free1     = !v1_ff || free2;
   assign move1     = v1_ff && free2;
   assign req_ready = free1;
   assign req_fire  = req_valid && req_ready;

   // ---------------------------------------------------------------------
   // Capture stage: per-channel arm/measure state and pulse width
   // ---------------------------------------------------------------------
   logic [NUM_CHANNELS-1:0] req_hit;
   logic                    req_ch_ok;
   logic [StampW-1:0]       stamp_q;
   logic                    sel_armed;
   logic [StampW-1:0]       sel_start;
   logic [WidthW-1:0]       sel_width;
   logic [RegW-1:0]         wrap_head;
   logic [WidthW-1:0]       new_width;

   logic [NUM_CHANNELS-1:0] armed_ff, armed_in;
   logic [StampW-1:0]       start_ff [NUM_CHANNELS];
   logic [StampW-1:0]       start_in [NUM_CHANNELS];
   logic [WidthW-1:0]       width_ff [NUM_CHANNELS];
   logic [WidthW-1:0]       width_in [NUM_CHANNELS];

   assign stamp_q = req_capture_stamp[StampW-1:0];

   always_comb begin
      sel_armed = 1'b0;
      sel_start = '0;
      sel_width = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         req_hit[i] = (int'(req_channel_select) == i);
         if (req_hit[i]) begin
            sel_armed = armed_ff[i];
            sel_start = start_ff[i];
            sel_width = width_ff[i];
         end
      end
      req_ch_ok = |req_hit;
   end

   // timer wrapped: (wrap_max - start) + end, head clamped at zero
   assign wrap_head = (wrap_max_ff > RegW'(sel_start)) ? (wrap_max_ff - RegW'(sel_start))
                                                       : '0;

   always_comb begin
      priority if (stamp_q > sel_start) begin
         new_width = WidthW'(stamp_q - sel_start);
      end else if (sel_start > stamp_q) begin
         new_width = WidthW'(wrap_head) + WidthW'(stamp_q);
      end else begin
         // equal stamps keep the previous width
         new_width = sel_width;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         armed_in[i] = armed_ff[i];
         start_in[i] = start_ff[i];
         width_in[i] = width_ff[i];
         if (req_fire && req_hit[i]) begin
            armed_in[i] = !armed_ff[i];
            if (armed_ff[i]) begin
               width_in[i] = new_width;
            end else begin
               start_in[i] = stamp_q;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            start_ff[i] <= '0;
            width_ff[i] <= '0;
         end
      end else begin
         armed_ff <= armed_in;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            start_ff[i] <= start_in[i];
            width_ff[i] <= width_in[i];
         end
      end
   end

   // stage 1 registers: width already scaled towards distance
   logic [ChanW-1:0]     s1_ch_ff;
   logic                 s1_done_ff;
   logic [DistProdW-1:0] s1_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (free1) begin
         v1_ff <= req_fire && req_ch_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (free1) begin
         s1_ch_ff   <= req_channel_select;
         s1_done_ff <= sel_armed;
         s1_prod_ff <= DistProdW'(new_width) * DistProdW'(ecrs_pkg::DistMul);
      end
   end

   // ---------------------------------------------------------------------
   // Distance stage: saturate and store the channel's distance
   // ---------------------------------------------------------------------
   logic [DistQW-1:0]                     dist_q;
   logic [RangeW-1:0]                     s1_dist;
   logic [NUM_CHANNELS-1:0][RangeW-1:0]   range_ff, range_in;

   assign dist_q  = s1_prod_ff[ecrs_pkg::DistShift +: DistQW];
   assign s1_dist = (dist_q > DistQW'(ecrs_pkg::RangeMax)) ? RangeW'(ecrs_pkg::RangeMax)
                                                          : dist_q[RangeW-1:0];

   always_comb begin
      range_in = range_ff;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (move1 && s1_done_ff && (int'(s1_ch_ff) == i)) begin
            range_in[i] = s1_dist;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= '0;
      end else begin
         range_ff <= range_in;
      end
   end

   logic [ChanW-1:0] s2_ch_ff;
   logic             s2_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (free2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (free2) begin
         s2_ch_ff   <= s1_ch_ff;
         s2_done_ff <= s1_done_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Statistics stage: ranges already hold this beat's write
   // ---------------------------------------------------------------------
   logic [SumW-1:0]   st_sum;
   logic [RangeW-1:0] st_min;
   logic [RangeW-1:0] st_max;
   logic [RangeW-1:0] s2_range;

   ecrs_stats #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_stats (
      .ranges    (range_ff),
      .range_sum (st_sum),
      .range_min (st_min),
      .range_max (st_max)
   );

   always_comb begin
      s2_range = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (int'(s2_ch_ff) == i) begin
            s2_range = range_ff[i];
         end
      end
   end

   logic [ChanW-1:0]  s3_ch_ff;
   logic              s3_done_ff;
   logic [RangeW-1:0] s3_range_ff;
   logic [SumW-1:0]   s3_sum_ff;
   logic [RangeW-1:0] s3_min_ff;
   logic [RangeW-1:0] s3_max_ff;
   logic [PprodW-1:0] s3_pprod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (free3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (free3) begin
         s3_ch_ff    <= s2_ch_ff;
         s3_done_ff  <= s2_done_ff;
         s3_range_ff <= s2_range;
         s3_sum_ff   <= st_sum;
         s3_min_ff   <= st_min;
         s3_max_ff   <= st_max;
         s3_pprod_ff <= PprodW'(pwm_reload_ff) * PprodW'(s2_range);
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: constant divisions by reciprocal, result register
   // ---------------------------------------------------------------------
   logic [AvgProdW-1:0]  avg_prod;
   logic [DutyProdW-1:0] duty_prod;

   assign avg_prod  = AvgProdW'(s3_sum_ff) * AvgProdW'(AvgMul);
   assign duty_prod = DutyProdW'(s3_pprod_ff) * DutyProdW'(ecrs_pkg::DutyMul);

   logic [ChanW-1:0]  rsp_ch_ff;
   logic              rsp_done_ff;
   logic [RangeW-1:0] rsp_range_ff;
   logic [RangeW-1:0] rsp_avg_ff;
   logic [RangeW-1:0] rsp_min_ff;
   logic [RangeW-1:0] rsp_max_ff;
   logic [DutyW-1:0]  rsp_duty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_ch_ff    <= s3_ch_ff;
         rsp_done_ff  <= s3_done_ff;
         rsp_range_ff <= s3_range_ff;
         rsp_avg_ff   <= avg_prod[AvgShift +: RangeW];
         rsp_min_ff   <= s3_min_ff;
         rsp_max_ff   <= s3_max_ff;
         rsp_duty_ff  <= duty_prod[ecrs_pkg::DutyShift +: DutyW];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_channel   = rsp_ch_ff;
   assign rsp_measure_done  = rsp_done_ff;
   assign rsp_channel_range = rsp_range_ff;
   assign rsp_range_average = rsp_avg_ff;
   assign rsp_range_minimum = rsp_min_ff;
   assign rsp_range_maximum = rsp_max_ff;
   assign rsp_duty_compare  = rsp_duty_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_arm_chk
      a_arm_toggles: assert property (@(posedge clock) disable iff (reset)
         (req_fire && req_hit[g]) |=> (armed_ff[g] != $past(armed_ff[g])))
         else $error("channel arm flag did not toggle on its capture beat");
   end

   a_range_write_only_on_measure: assert property (@(posedge clock) disable iff (reset)
      !(move1 && s1_done_ff) |=> $stable(range_ff))
      else $error("stored distance changed without a completed measurement");

   a_ready_only_blocked_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (v1_ff && v2_ff && v3_ff && rsp_valid_ff))
      else $error("request side stalled with an empty stage");

   a_avg_within_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_range_minimum <= rsp_range_average) &&
                     (rsp_range_average <= rsp_range_maximum)))
      else $error("average outside minimum/maximum");

   a_channel_within_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_range_minimum <= rsp_channel_range) &&
                     (rsp_channel_range <= rsp_range_maximum)))
      else $error("channel distance outside minimum/maximum");

endmodule

`default_nettype wire
